// ===== rtl/tfd_pkg.sv =====
// shared types, constants and message helpers for the time/frequency converter
// no dependencies
package tfd_pkg;

  localparam int FIELD_SLOTS = 24;

  localparam logic [7:0] CH_PCT  = 8'h25;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_STAR = 8'h2a;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_A    = 8'h61;
  // constant bytes 1..31 of the message fold to this value
  localparam logic [7:0] CONST_XOR = 8'h22;

  // final byte at this position or later gives a frame of at least 43 bytes
  localparam logic [5:0] LAST_POS_MIN = 6'd42;
  localparam logic [5:0] MSG_LAST     = 6'd35;
  localparam logic [5:0] COUNT_MAX    = 6'd63;

  typedef logic [4:0] slot_t;

  typedef struct packed {
    logic                        err;
    logic [7:0]                  xsum;
    logic [FIELD_SLOTS-1:0][7:0] fields;
  } job_t;

  function automatic logic [7:0] hex_lower(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) r = CH_ZERO + {4'd0, nib};
    else r = CH_A + {4'd0, nib - 4'd10};
    return r;
  endfunction

  function automatic logic [7:0] msg_byte(input logic [5:0] k, input job_t j);
    logic [5:0] off;
    logic [7:0] r;
    off = '0;
    if (k == 6'd0) r = CH_PCT;
    else if (k == 6'd3) r = CH_EIGHT;
    else if (k <= 6'd6) r = CH_ZERO;
    else if (k <= 6'd18) begin
      off = k - 6'd7;
      r = j.fields[off[4:0]];
    end else if (k == 6'd19) r = CH_STAR;
    else if (k <= 6'd31) begin
      off = k - 6'd8;
      r = j.fields[off[4:0]];
    end else if (k == 6'd32) r = hex_lower(j.xsum[7:4]);
    else if (k == 6'd33) r = hex_lower(j.xsum[3:0]);
    else if (k == 6'd34) r = CH_CR;
    else r = CH_LF;
    return r;
  endfunction

endpackage

// ===== rtl/tfd_front.sv =====
// front end: counts frame bytes, keeps the field bytes and their xor
// builds one job per frame; depends on tfd_pkg
module tfd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    data_byte,
  input  logic          last_in,
  output logic          job_push,
  output tfd_pkg::job_t job
);
  import tfd_pkg::*;

  logic [5:0] byte_count;
  logic [7:0] running_xor;
  logic [FIELD_SLOTS-1:0][7:0] field_store;
  logic       kept;
  slot_t      slot;

  // frame position to store slot
  always_comb begin
    kept = 1'b1;
    slot = '0;
    if (byte_count >= 6'd4 && byte_count <= 6'd15) slot = 5'(byte_count - 6'd4);
    else if (byte_count == 6'd17 || byte_count == 6'd18) slot = 5'(byte_count - 6'd5);
    else if (byte_count >= 6'd20 && byte_count <= 6'd23) slot = 5'(byte_count - 6'd6);
    else if (byte_count >= 6'd25 && byte_count <= 6'd30) slot = 5'(byte_count - 6'd7);
    else kept = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      running_xor <= '0;
    end else if (accept) begin
      if (last_in) begin
        byte_count <= '0;
        running_xor <= '0;
      end else begin
        if (byte_count != COUNT_MAX) byte_count <= byte_count + 6'd1;
        if (kept) running_xor <= running_xor ^ data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && kept) field_store[slot] <= data_byte;
  end

  // a message frame ends past every kept position, so the store is complete
  assign job_push    = accept && last_in;
  assign job.err     = byte_count < LAST_POS_MIN;
  assign job.xsum    = running_xor ^ CONST_XOR;
  assign job.fields  = field_store;

endmodule

// ===== rtl/tfd_job_fifo.sv =====
// two-entry job queue between front and back
// depends on tfd_pkg
module tfd_job_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  tfd_pkg::job_t din,
  output logic          full,
  input  logic          rd,
  output tfd_pkg::job_t dout,
  output logic          nonempty
);
  import tfd_pkg::*;

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign full     = count == 2'd2;
  assign nonempty = count != 2'd0;
  assign do_wr    = wr && !full;
  assign do_rd    = rd && nonempty;
  assign dout     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (do_wr) wr_ptr <= ~wr_ptr;
      if (do_rd) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= din;
  end

endmodule

// ===== rtl/tfd_back.sv =====
// back end: walks one job out as 36 message bytes or a single error item
// depends on tfd_pkg
module tfd_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_ready,
  input  tfd_pkg::job_t job_in,
  output logic          job_take,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte,
  output logic          last_out,
  output logic          frame_error
);
  import tfd_pkg::*;

  logic       busy;
  logic [5:0] idx;
  job_t       cur;
  logic       out_acc;

  assign empty       = !busy;
  assign out_acc     = pop && busy;
  assign last_out    = cur.err || idx == MSG_LAST;
  assign frame_error = cur.err;
  assign out_byte    = cur.err ? 8'd0 : msg_byte(idx, cur);
  assign job_take    = job_ready && (!busy || (out_acc && last_out));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= '0;
    end else if (job_take) begin
      busy <= 1'b1;
      idx <= '0;
    end else if (out_acc) begin
      if (last_out) busy <= 1'b0;
      else idx <= idx + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) cur <= job_in;
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= MSG_LAST)
    else $error("message index past end");
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    (busy && cur.err) |-> idx == 6'd0)
    else $error("error item advanced index");
  a_mid_run: assert property (@(posedge clk) disable iff (rst)
    (out_acc && !last_out) |=> (busy && idx == $past(idx) + 6'd1))
    else $error("message run broke off");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    (busy && !out_acc) |-> !job_take)
    else $error("job loaded over running message");

endmodule

// ===== rtl/time_freq_frame_to_dlt1100_unit.sv =====
// top level of the time/frequency frame to DL/T 1100 message converter
// depends on tfd_pkg, tfd_front, tfd_job_fifo, tfd_back
//
//   channel   handshake        payload
//   input     push / full      data_byte[7:0], last_in
//   result    empty / pop      out_byte[7:0], last_out, frame_error
//
// input bytes are taken one per cycle while full is low; full rises only while the job queue
// holds two finished frames that the back end has not started
// a good frame yields 36 result items, one per cycle while pop is high;
// a short frame yields one error item
// rst clears counters, xor and queue pointers; stored field bytes have no reset
module time_freq_frame_to_dlt1100_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       last_in,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       last_out,
  output logic       frame_error
);
  import tfd_pkg::*;

  logic accept;
  logic job_push;
  job_t job_w;
  job_t job_q;
  logic q_nonempty;
  logic job_take;

  assign accept = push && !full;

  tfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .last_in   (last_in),
    .job_push  (job_push),
    .job       (job_w)
  );

  tfd_job_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (job_push),
    .din      (job_w),
    .full     (full),
    .rd       (job_take),
    .dout     (job_q),
    .nonempty (q_nonempty)
  );

  tfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_ready   (q_nonempty),
    .job_in      (job_q),
    .job_take    (job_take),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .last_out    (last_out),
    .frame_error (frame_error)
  );

endmodule

// ===== sim/tfd_checker.sv =====
`timescale 1ns / 1ps
// checker for the time/frequency frame converter: rebuilds each DL/T 1100 message
// from the accepted frame bytes and compares every result item in order
// standalone, watches the DUT ports only
module tfd_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] data_byte,
  input  logic       last_in,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_byte,
  input  logic       last_out,
  input  logic       frame_error,
  output int         fail_count,
  output int         pending,
  output int         checked
);

  localparam int FIELD_SLOTS = 24;
  localparam int FRAME_MIN   = 43;
  localparam int MSG_LEN     = 36;
  localparam int XOR_FIRST   = 1;
  localparam int XOR_LAST    = 31;
  localparam int REPORT_MAX  = 10;

  localparam logic [5:0] COUNT_SAT  = 6'd63;
  localparam logic [7:0] CH_PCT     = 8'h25;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_EIGHT   = 8'h38;
  localparam logic [7:0] CH_STAR    = 8'h2a;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_LF      = 8'h0a;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       err;
  } msg_item_t;

  msg_item_t  msg_queue[$];
  logic [5:0] frame_pos;
  logic [7:0] kept [FIELD_SLOTS];
  logic [7:0] field_xor;

  initial begin
    fail_count = 0;
    pending = 0;
    checked = 0;
    frame_pos = '0;
    field_xor = '0;
  end

  // frame position to store slot, -1 where the byte is dropped
  function automatic int slot_for(input logic [5:0] pos);
    int p;
    p = pos;
    if (p >= 4 && p <= 15) return p - 4;
    if (p == 17 || p == 18) return p - 5;
    if (p >= 20 && p <= 23) return p - 6;
    if (p >= 25 && p <= 30) return p - 7;
    return -1;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    if (nib < 4'd10) return CH_ZERO + {4'd0, nib};
    return CH_LOWER_A + {4'd0, nib} - 8'd10;
  endfunction

  function automatic msg_item_t make_item(input logic [7:0] value, input logic last,
                                          input logic err);
    msg_item_t it;
    it.value = value;
    it.last = last;
    it.err = err;
    return it;
  endfunction

  task automatic queue_message();
    logic [7:0] text [MSG_LEN];
    logic [7:0] sum;
    for (int k = 0; k < MSG_LEN; k++) begin
      if (k == 0) text[k] = CH_PCT;
      else if (k == 3) text[k] = CH_EIGHT;
      else if (k <= 6) text[k] = CH_ZERO;
      else if (k <= 18) text[k] = kept[k - 7];
      else if (k == 19) text[k] = CH_STAR;
      else if (k <= 31) text[k] = kept[k - 8];
      else if (k == 34) text[k] = CH_CR;
      else if (k == 35) text[k] = CH_LF;
      else text[k] = 8'h00;
    end
    sum = '0;
    for (int k = XOR_FIRST; k <= XOR_LAST; k++) sum = sum ^ text[k];
    text[32] = hex_digit(sum[7:4]);
    text[33] = hex_digit(sum[3:0]);
    for (int k = 0; k < MSG_LEN; k++)
      msg_queue = {msg_queue, make_item(text[k], k == MSG_LEN - 1, 1'b0)};
  endtask

  task automatic report_fail(input string what, input msg_item_t want);
    fail_count++;
    if (fail_count <= REPORT_MAX)
      $display("%0t: %s at result item %0d: expected %h last %b err %b, got %h last %b err %b",
               $realtime, what, checked, want.value, want.last, want.err,
               out_byte, last_out, frame_error);
  endtask

  always @(posedge clk) begin
    msg_item_t  want;
    logic [5:0] pos;
    int         slot;
    if (rst) begin
      frame_pos = '0;
      field_xor = '0;
      msg_queue.delete();
    end else begin
      if (pop && !empty) begin
        if (msg_queue.size() == 0) begin
          report_fail("unexpected item", make_item(8'h00, 1'b0, 1'b0));
        end else begin
          want = msg_queue.pop_front();
          if (out_byte !== want.value || last_out !== want.last ||
              frame_error !== want.err)
            report_fail("mismatch", want);
        end
        checked++;
      end
      if (push && !full) begin
        pos = frame_pos;
        slot = slot_for(pos);
        if (slot >= 0) begin
          kept[slot] = data_byte;
          field_xor = field_xor ^ data_byte;
        end
        if (frame_pos != COUNT_SAT) frame_pos = frame_pos + 6'd1;
        if (last_in) begin
          // frame length is the position of its last byte plus one
          if (int'(pos) + 1 < FRAME_MIN)
            msg_queue = {msg_queue, make_item(8'h00, 1'b1, 1'b1)};
          else queue_message();
          frame_pos = '0;
          field_xor = '0;
        end
      end
    end
    pending = msg_queue.size();
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// top of the converter testbench: clock, reset, frame stimulus under three pacing
// phases and the verdict; depends on time_freq_frame_to_dlt1100_unit and tfd_checker
module testbench;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int FRAME_MIN    = 43;
  localparam int PHASE_BYTES  = 20;
  localparam int DRAIN_CYCLES = 80;

  typedef enum int {FILL_RANDOM, FILL_DIGITS, FILL_ZERO, FILL_ONES} fill_t;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] data_byte;
  logic       last_in;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte;
  logic       last_out;
  logic       frame_error;

  int fail_count;
  int pending;
  int checked;
  int send_idle = 0;
  int recv_idle = 0;
  int cycles = 0;
  int bytes_sent = 0;
  int good_frames = 0;
  int short_frames = 0;

  time_freq_frame_to_dlt1100_unit DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .data_byte(data_byte),
    .last_in(last_in),
    .empty(empty),
    .pop(pop),
    .out_byte(out_byte),
    .last_out(last_out),
    .frame_error(frame_error)
  );

  tfd_checker scoreboard (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .data_byte(data_byte),
    .last_in(last_in),
    .empty(empty),
    .pop(pop),
    .out_byte(out_byte),
    .last_out(last_out),
    .frame_error(frame_error),
    .fail_count(fail_count),
    .pending(pending),
    .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: pop at random, never during reset
  always @(negedge clk) begin
    if (rst) pop = 1'b0;
    else pop = ($urandom_range(99) >= recv_idle);
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic [7:0] value, input logic last);
    while ($urandom_range(99) < send_idle) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    data_byte = value;
    last_in = last;
    do @(posedge clk); while (full);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input int len, input fill_t fill);
    logic [7:0] value;
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_DIGITS: value = 8'($urandom_range(8'h39, 8'h30));
        FILL_ZERO:   value = 8'h00;
        FILL_ONES:   value = 8'hff;
        default:     value = 8'($urandom);
      endcase
      send_item(value, i == len - 1);
    end
    if (len < FRAME_MIN) short_frames++;
    else good_frames++;
  endtask

  task automatic send_random_frame();
    int r;
    int len;
    r = $urandom_range(99);
    if (r < 15) len = $urandom_range(FRAME_MIN - 1, 1);
    else if (r < 30) len = $urandom_range(90, FRAME_MIN + 6);
    else len = $urandom_range(FRAME_MIN + 5, FRAME_MIN);
    send_frame(len, ($urandom_range(1) == 1) ? FILL_DIGITS : FILL_RANDOM);
  endtask

  initial begin
    int target;
    rst = 1'b1;
    push = 1'b0;
    data_byte = 8'h00;
    last_in = 1'b0;
    pop = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 21;
          recv_idle = 51;
        end
        1: begin
          send_idle = 51;
          recv_idle = 21;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      if (phase == 0) begin
        // one-byte frame, one byte short, shortest good frame, counter saturation
        send_frame(1, FILL_ONES);
        send_frame(FRAME_MIN - 1, FILL_ZERO);
        send_frame(FRAME_MIN, FILL_ONES);
        send_frame(FRAME_MIN, FILL_ZERO);
        send_frame(70, FILL_DIGITS);
      end
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) send_random_frame();
    end
    push = 1'b0;
    last_in = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d input bytes in %0d frames: %0d short, %0d of 43 bytes or more",
             bytes_sent, short_frames + good_frames, short_frames, good_frames);
    $display("compared %0d result items under three push/pop pacing phases", checked);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== time_freq_frame_to_dlt1100_unit.f =====
rtl/tfd_pkg.sv
rtl/tfd_front.sv
rtl/tfd_job_fifo.sv
rtl/tfd_back.sv
rtl/time_freq_frame_to_dlt1100_unit.sv
sim/tfd_checker.sv
sim/testbench.sv
